// ===== hw/rtl/decimal_telemetry_frame_encoder_macros.svh =====
// Assertion helpers shared by the encoder RTL.
`ifndef DECIMAL_TELEMETRY_FRAME_ENCODER_MACROS_SVH
`define DECIMAL_TELEMETRY_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DTFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DTFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dtfe_pkg.sv =====
`default_nettype none

package dtfe_pkg;

  // Frame bytes
  localparam logic [7:0]  STAR_CHAR  = 8'h2A;
  localparam logic [3:0]  DIGIT_HI   = 4'h3;   // '0'..'9' are 0x30..0x39
  localparam logic [7:0]  POINT_CHAR = 8'h2E;
  localparam logic [15:0] FIX_LIMIT  = 16'd9999;

  localparam int unsigned NUM_DIGITS = 5;
  localparam logic [2:0]  LAST_IDX   = 3'd7;

  // One converted request waiting for the emitter
  typedef struct packed {
    logic       func;
    logic [7:0] cmd_char;
    logic [3:0] dig0;   // ten thousands
    logic [3:0] dig1;   // thousands
    logic [3:0] dig2;   // hundreds
    logic [3:0] dig3;   // tens
    logic [3:0] dig4;   // ones
  } frame_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // d times the decimal weight handled at conversion step stp
  function automatic logic [16:0] step_mult(input logic [1:0] stp, input logic [3:0] d);
    logic [16:0] w;
    case (stp)
      2'd0:    w = 17'd10000;
      2'd1:    w = 17'd1000;
      2'd2:    w = 17'd100;
      default: w = 17'd10;
    endcase
    return 17'(w * {13'd0, d});
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dtfe_front.sv =====
`default_nettype none

module dtfe_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire logic              func_i,
  input  wire logic [7:0]        cmd_char_i,
  input  wire logic [15:0]       value_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output dtfe_pkg::frame_t       frame_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [1:0]  step_q, step_d;
  logic [15:0] rem_q, rem_d;
  logic [3:0]  dig_q [dtfe_pkg::NUM_DIGITS];
  logic        func_q;
  logic [7:0]  cmd_q;
  logic        accept;
  logic [3:0]  digit;
  logic [16:0] sub;
  logic [16:0] diff;

  // One decimal digit per cycle: largest d with d*weight <= remainder
  always_comb begin
    digit = 4'd0;
    sub   = 17'd0;
    for (int d = 1; d <= 9; d++) begin
      if ({1'b0, rem_q} >= dtfe_pkg::step_mult(step_q, 4'(d))) begin
        digit = 4'(d);
        sub   = dtfe_pkg::step_mult(step_q, 4'(d));
      end
    end
    diff = {1'b0, rem_q} - sub;
  end

  assign q_push_o = (state_q == ST_PUSH) && !q_full_i;
  assign full_o   = (state_q == ST_CONV) || ((state_q == ST_PUSH) && q_full_i);
  assign accept   = push_i && !full_o;

  // Sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    rem_d   = rem_q;
    case (state_q)
      ST_IDLE, ST_PUSH: begin
        if (q_push_o || (state_q == ST_IDLE)) begin
          state_d = ST_IDLE;
        end
        if (accept) begin
          state_d = ST_CONV;
          step_d  = 2'd0;
          // fixed mode saturates at 9.999
          rem_d   = (func_i && (value_i > dtfe_pkg::FIX_LIMIT)) ?
                    dtfe_pkg::FIX_LIMIT : value_i;
        end
      end
      ST_CONV: begin
        rem_d  = diff[15:0];
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d = ST_PUSH;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (accept) begin
      func_q <= func_i;
      cmd_q  <= cmd_char_i;
    end
    if (state_q == ST_CONV) begin
      dig_q[{1'b0, step_q}] <= digit;
      if (step_q == 2'd3) begin
        dig_q[4] <= diff[3:0];
      end
    end
  end

  always_comb begin
    frame_o.func     = func_q;
    frame_o.cmd_char = cmd_q;
    frame_o.dig0     = dig_q[0];
    frame_o.dig1     = dig_q[1];
    frame_o.dig2     = dig_q[2];
    frame_o.dig3     = dig_q[3];
    frame_o.dig4     = dig_q[4];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dtfe_queue.sv =====
`default_nettype none

module dtfe_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  dtfe_pkg::q_ctrl_t      ctrl_i,
  output dtfe_pkg::q_stat_t      stat_o,
  input  dtfe_pkg::frame_t       wdata_i,
  output dtfe_pkg::frame_t       rdata_o
);

  // Two-entry queue of converted requests
  dtfe_pkg::frame_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign do_push      = ctrl_i.push && !stat_o.full;
  assign do_pop       = ctrl_i.pop && !stat_o.empty;
  assign rdata_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dtfe_back.sv =====
`default_nettype none

module dtfe_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  dtfe_pkg::frame_t       frame_i,
  input  wire logic              q_empty_i,
  output logic                   q_pop_o,
  output logic                   empty_o,
  input  wire logic              pop_i,
  output logic [7:0]             tx_byte_o,
  output logic                   last_byte_o
);

  logic [2:0] idx_q;
  logic       ovalid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       advance, load;
  logic [7:0] sel;

  assign advance = !ovalid_q || pop_i;
  assign load    = advance && !q_empty_i;
  assign q_pop_o = load && (idx_q == dtfe_pkg::LAST_IDX);

  // Byte of the frame at position idx_q
  always_comb begin
    case (idx_q)
      3'd0:    sel = dtfe_pkg::STAR_CHAR;
      3'd1:    sel = frame_i.cmd_char;
      3'd2:    sel = {dtfe_pkg::DIGIT_HI, frame_i.func ? frame_i.dig1 : frame_i.dig0};
      3'd3:    sel = frame_i.func ? dtfe_pkg::POINT_CHAR :
                     {dtfe_pkg::DIGIT_HI, frame_i.dig1};
      3'd4:    sel = {dtfe_pkg::DIGIT_HI, frame_i.dig2};
      3'd5:    sel = {dtfe_pkg::DIGIT_HI, frame_i.dig3};
      3'd6:    sel = {dtfe_pkg::DIGIT_HI, frame_i.dig4};
      default: sel = dtfe_pkg::STAR_CHAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= 3'd0;
      ovalid_q <= 1'b0;
    end else if (load) begin
      idx_q    <= idx_q + 3'd1;
      ovalid_q <= 1'b1;
    end else if (advance) begin
      ovalid_q <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= sel;
      last_q <= (idx_q == dtfe_pkg::LAST_IDX);
    end
  end

  assign empty_o     = !ovalid_q;
  assign tx_byte_o   = byte_q;
  assign last_byte_o = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/decimal_telemetry_frame_encoder.sv =====
// Decimal telemetry frame encoder.
// Input side is a queue: a request (func_i, cmd_char_i, value_i) is taken on a
// clock edge with push high and full low. Output side is a queue too: the
// oldest byte sits on tx_byte_o/last_byte_o while empty is low and leaves on
// an edge with pop high. Each request yields eight bytes: '*', the command,
// five decimal digits (integer mode) or d.ddd (fixed mode, saturated at
// 9.999), and a closing '*' flagged by last_byte_o.
// The front converts the value to digits, one decimal weight per step; the
// request then passes a two-entry queue to the byte emitter and its output
// register. Bytes go out one per cycle while pop is held high and the queue
// holds a request; the byte emitter limits the request rate. full is high
// while every request converts. A stalled receiver fills the output
// register, then the queue, then the front, which holds full high until the
// queue has room again. Reset clears all control state; the block is empty
// and ready afterwards.
`default_nettype none
`include "decimal_telemetry_frame_encoder_macros.svh"

module decimal_telemetry_frame_encoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        func_i,
  input  wire logic [7:0]  cmd_char_i,
  input  wire logic [15:0] value_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       tx_byte_o,
  output logic             last_byte_o
);

  dtfe_pkg::frame_t  fr_front, fr_head;
  dtfe_pkg::q_ctrl_t q_ctrl;
  dtfe_pkg::q_stat_t q_stat;

  dtfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .func_i     (func_i),
    .cmd_char_i (cmd_char_i),
    .value_i    (value_i),
    .q_full_i   (q_stat.full),
    .q_push_o   (q_ctrl.push),
    .frame_o    (fr_front)
  );

  dtfe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (q_ctrl),
    .stat_o  (q_stat),
    .wdata_i (fr_front),
    .rdata_o (fr_head)
  );

  dtfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_i     (fr_head),
    .q_empty_i   (q_stat.empty),
    .q_pop_o     (q_ctrl.pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .tx_byte_o   (tx_byte_o),
    .last_byte_o (last_byte_o)
  );

  // Front never pushes into a full queue
  `DTFE_ASSERT_NOW(a_no_overflow, q_ctrl.push, !q_stat.full, "push into full queue")
  // An accepted request keeps the front busy while it converts
  `DTFE_ASSERT_NEXT(a_busy_after_accept, push && !full, full, "front took two requests")
  // The flagged byte is always the closing star
  `DTFE_ASSERT_NOW(a_last_is_star, !empty && last_byte_o, tx_byte_o == dtfe_pkg::STAR_CHAR,
                   "last byte is not a star")

endmodule

`default_nettype wire
